>>> src/vsft_pkg.sv
// Shared types and constants for the virtual switch forwarding table.
// Used by vsft_ctrl, vsft_datapath and the top level; no dependencies.
package vsft_pkg;

  localparam int MAC_W     = 48;
  localparam int MACNUM_W  = 32;
  localparam int STATUS_W  = 3;
  localparam int SLOT_W    = 4;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;
  localparam int MAX_RES   = 16;
  localparam int CNT_W     = 5;
  localparam int MCAST_BIT = 40;

  localparam logic [15:0] ASSIGNED_PREFIX = 16'hFEFD;
  localparam logic [MACNUM_W-1:0] LAST_MAC_RESET = 32'hFFFF_FFFE;

  // opcodes
  localparam logic [1:0] OP_CONNECT  = 2'd0;
  localparam logic [1:0] OP_ASSIGNED = 2'd1;
  localparam logic [1:0] OP_DROP     = 2'd2;
  localparam logic [1:0] OP_FRAME    = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOMAC   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NODEST  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTCONN = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HUB_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MAC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_MAC   = 2'd2;

  // result source select
  typedef logic [2:0] emit_sel_t;
  localparam emit_sel_t SEL_ALLOC_OK = 3'd0;
  localparam emit_sel_t SEL_FULL     = 3'd1;
  localparam emit_sel_t SEL_NOMAC    = 3'd2;
  localparam emit_sel_t SEL_NOTCONN  = 3'd3;
  localparam emit_sel_t SEL_DROP_OK  = 3'd4;
  localparam emit_sel_t SEL_PEND     = 3'd5;
  localparam emit_sel_t SEL_NODEST   = 3'd6;

  typedef struct packed {
    logic      load;         // latch request fields, reset scan
    logic      idx_inc;
    logic      alloc_write;  // take slot at idx
    logic      drop_clear;   // free slot at idx
    logic      rd;           // read MAC RAM at idx
    logic      pend_set;     // hold current hit as pending result
    logic      pend_clear;
    logic      emit;
    emit_sel_t emit_sel;
    logic      emit_last;
  } vsft_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       out_free;
    logic       slot_busy;
    logic       idx_end;
    logic       mac_exhausted;
    logic       drop_ok;
    logic       hit;
    logic       pend_valid;
    logic       cnt_last;
  } vsft_stat_t;

endpackage

>>> src/vsft_ctrl.sv
// Sequencer for the forwarding table: connect scan, disconnect, frame scan.
// Depends on vsft_pkg; drives vsft_datapath through vsft_cmd_t.
module vsft_ctrl import vsft_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  vsft_stat_t stat,
  output vsft_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_ALLOC    = 3'd2;
  localparam logic [2:0] S_FAIL     = 3'd3;
  localparam logic [2:0] S_DROP_RD  = 3'd4;
  localparam logic [2:0] S_DROP_RSP = 3'd5;
  localparam logic [2:0] S_FR_RD    = 3'd6;
  localparam logic [2:0] S_FR_CHK   = 3'd7;

  logic [2:0] state, state_next;
  emit_sel_t  fail_sel, fail_sel_next;
  logic       fr_end, fr_end_next;   // frame scan finished, flush pending

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      fail_sel <= SEL_FULL;
      fr_end   <= 1'b0;
    end else begin
      state    <= state_next;
      fail_sel <= fail_sel_next;
      fr_end   <= fr_end_next;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.emit_sel  = SEL_FULL;
    cmd.emit_last = 1'b1;
    state_next    = state;
    fail_sel_next = fail_sel;
    fr_end_next   = fr_end;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load    = 1'b1;
          fr_end_next = 1'b0;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.op)
          OP_CONNECT:  state_next = S_ALLOC;
          OP_ASSIGNED: begin
            if (stat.mac_exhausted) begin
              fail_sel_next = SEL_NOMAC;
              state_next    = S_FAIL;
            end else begin
              state_next = S_ALLOC;
            end
          end
          OP_DROP:     state_next = S_DROP_RD;
          default:     state_next = S_FR_RD;
        endcase
      end
      S_ALLOC: begin
        if (!stat.slot_busy) begin
          if (stat.out_free) begin
            cmd.alloc_write = 1'b1;
            cmd.emit        = 1'b1;
            cmd.emit_sel    = SEL_ALLOC_OK;
            state_next      = S_IDLE;
          end
        end else if (stat.idx_end) begin
          fail_sel_next = SEL_FULL;
          state_next    = S_FAIL;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_FAIL: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = fail_sel;
          state_next   = S_IDLE;
        end
      end
      S_DROP_RD: begin
        if (stat.drop_ok) begin
          cmd.rd     = 1'b1;
          state_next = S_DROP_RSP;
        end else begin
          fail_sel_next = SEL_NOTCONN;
          state_next    = S_FAIL;
        end
      end
      S_DROP_RSP: begin
        if (stat.out_free) begin
          cmd.drop_clear = 1'b1;
          cmd.emit       = 1'b1;
          cmd.emit_sel   = SEL_DROP_OK;
          state_next     = S_IDLE;
        end
      end
      S_FR_RD: begin
        if (fr_end) begin
          // flush the held match as the final result, or report no destination if none is held
          if (!stat.pend_valid) begin
            fail_sel_next = SEL_NODEST;
            state_next    = S_FAIL;
          end else if (stat.out_free) begin
            cmd.emit       = 1'b1;
            cmd.emit_sel   = SEL_PEND;
            cmd.pend_clear = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_FR_CHK;
        end
      end
      S_FR_CHK: begin
        if (stat.hit) begin
          if (!stat.pend_valid || stat.out_free) begin
            cmd.emit      = stat.pend_valid;
            cmd.emit_sel  = SEL_PEND;
            cmd.emit_last = 1'b0;
            cmd.pend_set  = 1'b1;
            if (stat.cnt_last || stat.idx_end) begin
              fr_end_next = 1'b1;
            end else begin
              cmd.idx_inc = 1'b1;
            end
            state_next = S_FR_RD;
          end
        end else begin
          if (stat.idx_end) begin
            fr_end_next = 1'b1;
          end else begin
            cmd.idx_inc = 1'b1;
          end
          state_next = S_FR_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> src/vsft_datapath.sv
// Datapath: config registers, MAC counter, slot valid bits, MAC RAM,
// pending-match holder and result register. Depends on vsft_pkg.
module vsft_datapath import vsft_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic [1:0]            opcode,
  input  logic [SLOT_W-1:0]     slot_to_drop,
  input  logic [MAC_W-1:0]      station_mac,
  input  logic [MAC_W-1:0]      frame_dest_mac,
  input  vsft_cmd_t             cmd,
  output vsft_stat_t            stat,
  output logic                  res_valid,
  input  logic                  res_stall,
  output logic [STATUS_W-1:0]   status,
  output logic [SLOT_W-1:0]     port_slot,
  output logic [MAC_W-1:0]      port_mac,
  output logic                  last
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_DEPTH - 1);

  logic                  hub_mode;
  logic [MACNUM_W-1:0]   last_mac_number;
  logic [MACNUM_W:0]     next_mac_number;

  logic [1:0]            op_q;
  logic [SLOT_W-1:0]     drop_q;
  logic [MAC_W-1:0]      smac_q;
  logic [MAC_W-1:0]      dmac_q;

  logic [IDX_W-1:0]      idx;
  logic [TABLE_DEPTH-1:0] slot_valid;
  logic [MAC_W-1:0]      mac_mem [TABLE_DEPTH];
  logic [MAC_W-1:0]      rd_data;

  logic [CNT_W-1:0]      match_cnt;
  logic                  pend_valid;
  logic [IDX_W-1:0]      pend_slot;
  logic [MAC_W-1:0]      pend_mac;

  logic [MAC_W-1:0]      new_mac;
  logic [STATUS_W-1:0]   e_status;
  logic [SLOT_W-1:0]     e_slot;
  logic [MAC_W-1:0]      e_mac;
  logic                  out_free;

  assign new_mac  = (op_q == OP_CONNECT) ? smac_q
                                         : {ASSIGNED_PREFIX, next_mac_number[MACNUM_W-1:0]};
  assign out_free = !res_valid || !res_stall;

  always_comb begin
    stat               = '0;
    stat.op            = op_q;
    stat.out_free      = out_free;
    stat.slot_busy     = slot_valid[idx];
    stat.idx_end       = (idx == IDX_LAST);
    stat.mac_exhausted = next_mac_number > {1'b0, last_mac_number};
    stat.drop_ok       = (9'(drop_q) < 9'(TABLE_DEPTH)) && slot_valid[idx];
    stat.hit           = slot_valid[idx] &&
                         (hub_mode || dmac_q[MCAST_BIT] || (rd_data == dmac_q));
    stat.pend_valid    = pend_valid;
    stat.cnt_last      = (match_cnt == CNT_W'(MAX_RES - 1));
  end

  // configuration and MAC counter
  always_ff @(posedge clk) begin
    if (rst) begin
      hub_mode        <= 1'b0;
      last_mac_number <= LAST_MAC_RESET;
      next_mac_number <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_HUB_MODE) hub_mode <= cfg_data[0];
      if (cfg_we && cfg_index == CFG_LAST_MAC) last_mac_number <= cfg_data;
      if (cfg_we && cfg_index == CFG_FIRST_MAC) begin
        next_mac_number <= {1'b0, cfg_data};
      end else if (cmd.alloc_write && op_q == OP_ASSIGNED) begin
        next_mac_number <= next_mac_number + 1'b1;
      end
    end
  end

  // request latch
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q   <= opcode;
      drop_q <= slot_to_drop;
      smac_q <= station_mac;
      dmac_q <= frame_dest_mac;
    end
  end

  // scan index
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.load) begin
      idx <= (opcode == OP_DROP) ? IDX_W'(slot_to_drop) : '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.alloc_write) begin
      slot_valid[idx] <= 1'b1;
    end else if (cmd.drop_clear) begin
      slot_valid[idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_write) mac_mem[idx] <= new_mac;
    if (cmd.rd) rd_data <= mac_mem[idx];
  end

  // the newest match is held back so the final one can carry last
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      match_cnt  <= '0;
    end else if (cmd.load || cmd.pend_clear) begin
      pend_valid <= 1'b0;
      match_cnt  <= '0;
    end else if (cmd.pend_set) begin
      pend_valid <= 1'b1;
      match_cnt  <= match_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pend_set) begin
      pend_slot <= idx;
      pend_mac  <= rd_data;
    end
  end

  always_comb begin
    e_status = ST_OK;
    e_slot   = '0;
    e_mac    = '0;
    case (cmd.emit_sel)
      SEL_ALLOC_OK: begin
        e_slot = SLOT_W'(idx);
        e_mac  = new_mac;
      end
      SEL_FULL:    e_status = ST_FULL;
      SEL_NOMAC:   e_status = ST_NOMAC;
      SEL_NOTCONN: begin
        e_status = ST_NOTCONN;
        e_slot   = drop_q;
      end
      SEL_DROP_OK: begin
        e_slot = drop_q;
        e_mac  = rd_data;
      end
      SEL_PEND: begin
        e_slot = SLOT_W'(pend_slot);
        e_mac  = pend_mac;
      end
      SEL_NODEST:  e_status = ST_NODEST;
      default:     e_status = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status    <= e_status;
      port_slot <= e_slot;
      port_mac  <= e_mac;
      last      <= cmd.emit_last;
    end
  end

endmodule

>>> src/virtual_switch_forwarding_table_core.sv
// Forwarding table top: one request at a time, taken the cycle after its last result.
// Connect scans valid bits one slot a cycle. Disconnect reads the slot's MAC, then frees
// it as it emits its result. A frame reads and then checks each slot of the MAC RAM in
// turn. A stalled result holds the sequencer. Results leave through a one-deep output
// register. Synchronous active-high rst clears slots, counter and hub_mode, and sets
// last_mac_number to 0xFFFFFFFE.
module virtual_switch_forwarding_table_core import vsft_pkg::*; #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           opcode,
  input  logic [SLOT_W-1:0]    slot_to_drop,
  input  logic [MAC_W-1:0]     station_mac,
  input  logic [MAC_W-1:0]     frame_dest_mac,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [STATUS_W-1:0]  status,
  output logic [SLOT_W-1:0]    port_slot,
  output logic [MAC_W-1:0]     port_mac,
  output logic                 last
);

  vsft_cmd_t  cmd;
  vsft_stat_t stat;

  vsft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  vsft_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .opcode         (opcode),
    .slot_to_drop   (slot_to_drop),
    .station_mac    (station_mac),
    .frame_dest_mac (frame_dest_mac),
    .cmd            (cmd),
    .stat           (stat),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .status         (status),
    .port_slot      (port_slot),
    .port_mac       (port_mac),
    .last           (last)
  );

endmodule

>>> sim/virtual_switch_forwarding_table_core_test.sv
// Self-checking testbench for virtual_switch_forwarding_table_core.
// Depends on vsft_pkg and the core RTL only. Directed table and edge cases, then random
// phases under several register settings, all scored against a built-in port table model.
module virtual_switch_forwarding_table_core_test;
  import vsft_pkg::*;

  localparam int DEPTH = 16;
  localparam int QUIET_CYCLES = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [MAC_W-1:0]    mac;
    logic                last;
  } port_result_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] drop;
    logic [MAC_W-1:0]  smac;
    logic [MAC_W-1:0]  dmac;
    logic              typed;
    port_result_t      want;
  } request_row_t;

  // Expected port is typed in where it is obvious; otherwise the table model decides.
  localparam request_row_t PLAN [0:19] = '{
    '{OP_DROP,     4'd0,  48'h0, 48'h0, 1'b1, {ST_NOTCONN, 4'd0, 48'h0, 1'b1}},
    '{OP_FRAME,    4'd0,  48'h0, 48'hFFFF_FFFF_FFFF, 1'b1, {ST_NODEST, 4'd0, 48'h0, 1'b1}},
    '{OP_CONNECT,  4'd0,  48'h0, 48'h0, 1'b1, {ST_OK, 4'd0, 48'h0, 1'b1}},
    '{OP_CONNECT,  4'd0,  48'hFFFF_FFFF_FFFF, 48'h0, 1'b1,
      {ST_OK, 4'd1, 48'hFFFF_FFFF_FFFF, 1'b1}},
    '{OP_ASSIGNED, 4'd0,  48'h0, 48'h0, 1'b1, {ST_OK, 4'd2, 48'hFEFD_0000_0000, 1'b1}},
    '{OP_ASSIGNED, 4'd0,  48'h0, 48'h0, 1'b1, {ST_OK, 4'd3, 48'hFEFD_0000_0001, 1'b1}},
    '{OP_FRAME,    4'd0,  48'h0, 48'h0, 1'b0, '0},
    '{OP_FRAME,    4'd0,  48'h0, 48'hFFFF_FFFF_FFFF, 1'b0, '0},
    '{OP_FRAME,    4'd0,  48'h0, 48'h0100_0000_0000, 1'b0, '0},
    '{OP_FRAME,    4'd0,  48'h0, 48'hFEFD_0000_0001, 1'b0, '0},
    '{OP_FRAME,    4'd0,  48'h0, 48'h1234_5678_9ABC, 1'b1, {ST_NODEST, 4'd0, 48'h0, 1'b1}},
    '{OP_DROP,     4'd1,  48'h0, 48'h0, 1'b1, {ST_OK, 4'd1, 48'hFFFF_FFFF_FFFF, 1'b1}},
    '{OP_DROP,     4'd1,  48'h0, 48'h0, 1'b1, {ST_NOTCONN, 4'd1, 48'h0, 1'b1}},
    '{OP_DROP,     4'd15, 48'h0, 48'h0, 1'b1, {ST_NOTCONN, 4'd15, 48'h0, 1'b1}},
    '{OP_CONNECT,  4'd0,  48'hAAAA_AAAA_AAAA, 48'h0, 1'b1,
      {ST_OK, 4'd1, 48'hAAAA_AAAA_AAAA, 1'b1}},
    '{OP_CONNECT,  4'd0,  48'hFEFD_0000_0001, 48'h0, 1'b1,
      {ST_OK, 4'd4, 48'hFEFD_0000_0001, 1'b1}},
    '{OP_FRAME,    4'd0,  48'h0, 48'hFEFD_0000_0001, 1'b0, '0},
    '{OP_FRAME,    4'd0,  48'h0, 48'h5555_5555_5555, 1'b0, '0},
    '{OP_ASSIGNED, 4'd0,  48'h0, 48'h0, 1'b1, {ST_OK, 4'd5, 48'hFEFD_0000_0002, 1'b1}},
    '{OP_DROP,     4'd0,  48'h0, 48'h0, 1'b1, {ST_OK, 4'd0, 48'h0, 1'b1}}
  };

  localparam port_result_t NOMAC_RESULT = {ST_NOMAC, 4'd0, 48'h0, 1'b1};
  localparam port_result_t FULL_RESULT = {ST_FULL, 4'd0, 48'h0, 1'b1};

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]    cfg_data;
  logic                req_valid;
  logic                req_stall;
  logic [1:0]          opcode;
  logic [SLOT_W-1:0]   slot_to_drop;
  logic [MAC_W-1:0]    station_mac;
  logic [MAC_W-1:0]    frame_dest_mac;
  logic                res_valid;
  logic                res_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   port_slot;
  logic [MAC_W-1:0]    port_mac;
  logic                last;

  // table model state
  logic                slot_used [DEPTH];
  logic                slot_written [DEPTH];
  logic [MAC_W-1:0]    slot_mac [DEPTH];
  logic [MACNUM_W:0]   mac_counter;
  logic                hub_on;
  logic [MACNUM_W-1:0] first_num;
  logic [MACNUM_W-1:0] last_num;

  port_result_t awaited_ports [$];
  port_result_t head;
  int errors = 0;
  int requests_sent = 0;
  int results_checked = 0;
  logic gaps_on = 1'b1;
  logic stall_on = 1'b1;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  virtual_switch_forwarding_table_core #(.TABLE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .req_valid(req_valid), .req_stall(req_stall),
    .opcode(opcode), .slot_to_drop(slot_to_drop),
    .station_mac(station_mac), .frame_dest_mac(frame_dest_mac),
    .res_valid(res_valid), .res_stall(res_stall),
    .status(status), .port_slot(port_slot), .port_mac(port_mac), .last(last)
  );

  always #5 clk = ~clk;

  function automatic port_result_t port_result(input logic [STATUS_W-1:0] st,
                                               input logic [SLOT_W-1:0] s,
                                               input logic [MAC_W-1:0] m, input logic l);
    port_result = {st, s, m, l};
  endfunction

  function automatic int first_free();
    int idx;
    idx = -1;
    for (int i = DEPTH - 1; i >= 0; i--) if (!slot_used[i]) idx = i;
    return idx;
  endfunction

  task automatic claim_slot(input int idx, input logic [MAC_W-1:0] mac);
    if (idx < 0) begin
      awaited_ports.push_back(FULL_RESULT);
    end else begin
      slot_used[idx] = 1'b1;
      slot_written[idx] = 1'b1;
      slot_mac[idx] = mac;
      awaited_ports.push_back(port_result(ST_OK, SLOT_W'(idx), mac, 1'b1));
    end
  endtask

  task automatic predict_table_op(input logic [1:0] op, input logic [SLOT_W-1:0] drop,
                                  input logic [MAC_W-1:0] smac, dmac);
    int free_idx;
    int hits;
    int hit_slots [DEPTH];
    free_idx = first_free();
    hits = 0;
    case (op)
      OP_CONNECT: claim_slot(free_idx, smac);
      OP_ASSIGNED: begin
        // range check wins over the table-full check
        if (mac_counter > {1'b0, last_num}) begin
          awaited_ports.push_back(NOMAC_RESULT);
        end else begin
          claim_slot(free_idx, {ASSIGNED_PREFIX, mac_counter[MACNUM_W-1:0]});
          if (free_idx >= 0) mac_counter++;
        end
      end
      OP_DROP: begin
        if (!slot_used[drop]) begin
          awaited_ports.push_back(port_result(ST_NOTCONN, drop, '0, 1'b1));
        end else begin
          slot_used[drop] = 1'b0;
          awaited_ports.push_back(port_result(ST_OK, drop, slot_mac[drop], 1'b1));
        end
      end
      default: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (slot_used[i] && (hub_on || dmac[MCAST_BIT] || slot_mac[i] == dmac)) begin
            hit_slots[hits] = i;
            hits++;
          end
        end
        if (hits == 0) awaited_ports.push_back(port_result(ST_NODEST, '0, '0, 1'b1));
        for (int k = 0; k < hits; k++)
          awaited_ports.push_back(port_result(ST_OK, SLOT_W'(hit_slots[k]),
                                              slot_mac[hit_slots[k]], k == hits - 1));
      end
    endcase
  endtask

  // called at a falling edge while the block is idle
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HUB_MODE: hub_on = data[0];
      CFG_FIRST_MAC: begin
        first_num = data;
        mac_counter = {1'b0, data};
      end
      CFG_LAST_MAC: last_num = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_request(input logic [1:0] op, input logic [SLOT_W-1:0] drop,
                              input logic [MAC_W-1:0] smac, dmac,
                              input logic typed, input port_result_t want);
    if (gaps_on && $urandom_range(0, 99) < 9) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 2 * DEPTH + 4)) @(negedge clk);
    end
    req_valid <= 1'b1;
    opcode <= op;
    slot_to_drop <= drop;
    station_mac <= smac;
    frame_dest_mac <= dmac;
    do @(posedge clk); while (req_stall);
    predict_table_op(op, drop, smac, dmac);
    if (typed) begin
      void'(awaited_ports.pop_back());
      awaited_ports.push_back(want);
    end
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (awaited_ports.size() != 0) @(negedge clk);
    repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[MAC_W-1:0];
  endfunction

  function automatic logic [MAC_W-1:0] known_mac();
    int i;
    i = $urandom_range(0, DEPTH - 1);
    return slot_written[i] ? slot_mac[i] : random_mac();
  endfunction

  function automatic logic [MAC_W-1:0] pick_station_mac();
    int k;
    k = $urandom_range(0, 99);
    if (k < 30) return known_mac();
    if (k < 40) return {ASSIGNED_PREFIX, 16'h0, 16'($urandom_range(0, 1200))};
    return random_mac();
  endfunction

  function automatic logic [MAC_W-1:0] pick_dest_mac();
    int k;
    logic [MAC_W-1:0] m;
    k = $urandom_range(0, 99);
    m = random_mac();
    if (k < 45) m = known_mac();
    else if (k < 62) m[MCAST_BIT] = 1'b0;
    else if (k < 75) m[MCAST_BIT] = 1'b1;
    else if (k < 80) m = {MAC_W{k[0]}};
    return m;
  endfunction

  task automatic run_phase(input int count, input int w_conn, input int w_assign,
                           input int w_drop, input int hold_at);
    int pick;
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_requests++;
      pick = $urandom_range(0, 99);
      if (pick < w_conn) op = OP_CONNECT;
      else if (pick < w_conn + w_assign) op = OP_ASSIGNED;
      else if (pick < w_conn + w_assign + w_drop) op = OP_DROP;
      else op = OP_FRAME;
      send_request(op, SLOT_W'($urandom_range(0, DEPTH - 1)), pick_station_mac(),
                   pick_dest_mac(), 1'b0, '0);
    end
  endtask

  // result side: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= stall_on && ($urandom_range(0, 99) < 9);
    end
  end

  task automatic check_field(input string what, input logic [MAC_W-1:0] want,
                             input logic [MAC_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (awaited_ports.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d mac=%h last=%b",
                 $time, status, port_slot, port_mac, last);
        errors++;
      end else begin
        head = awaited_ports.pop_front();
        check_field("status", MAC_W'(head.status), MAC_W'(status));
        check_field("port_slot", MAC_W'(head.slot), MAC_W'(port_slot));
        check_field("port_mac", head.mac, port_mac);
        check_field("last", MAC_W'(head.last), MAC_W'(last));
        results_checked++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_valid = 1'b0;
    opcode = OP_CONNECT;
    slot_to_drop = '0;
    station_mac = '0;
    frame_dest_mac = '0;
    for (int i = 0; i < DEPTH; i++) begin
      slot_used[i] = 1'b0;
      slot_written[i] = 1'b0;
      slot_mac[i] = '0;
    end
    mac_counter = '0;
    hub_on = 1'b0;
    first_num = '0;
    last_num = LAST_MAC_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < $size(PLAN); r++)
      send_request(PLAN[r].op, PLAN[r].drop, PLAN[r].smac, PLAN[r].dmac,
                   PLAN[r].typed, PLAN[r].want);
    settle();

    // top of the counter range: one assignment, then exhausted
    write_register(CFG_LAST_MAC, 32'hFFFF_FFFF);
    write_register(CFG_FIRST_MAC, 32'hFFFF_FFFF);
    send_request(OP_ASSIGNED, '0, '0, '0, 1'b0, '0);
    send_request(OP_ASSIGNED, '0, '0, '0, 1'b1, NOMAC_RESULT);
    settle();
    write_register(CFG_LAST_MAC, 32'd3);
    write_register(CFG_FIRST_MAC, 32'd5);
    send_request(OP_ASSIGNED, '0, '0, '0, 1'b1, NOMAC_RESULT);
    while (first_free() >= 0) send_request(OP_CONNECT, '0, random_mac(), '0, 1'b0, '0);
    send_request(OP_CONNECT, '0, random_mac(), '0, 1'b1, FULL_RESULT);
    settle();
    write_register(CFG_LAST_MAC, 32'hFFFF_FFFE);
    send_request(OP_ASSIGNED, '0, '0, '0, 1'b1, FULL_RESULT);
    settle();
    // full table and exhausted range: range status takes precedence
    write_register(CFG_LAST_MAC, 32'd0);
    write_register(CFG_HUB_MODE, 32'd1);
    send_request(OP_ASSIGNED, '0, '0, '0, 1'b1, NOMAC_RESULT);
    send_request(OP_FRAME, '0, '0, '0, 1'b0, '0);
    send_request(OP_DROP, 4'd15, '0, '0, 1'b0, '0);
    settle();

    write_register(CFG_HUB_MODE, 32'd0);
    write_register(CFG_FIRST_MAC, 32'd0);
    write_register(CFG_LAST_MAC, 32'hFFFF_FFFF);
    run_phase(110, 30, 15, 25, 30);
    settle();

    write_register(CFG_HUB_MODE, 32'd1);
    first_num = $urandom_range(0, 1000);
    write_register(CFG_FIRST_MAC, first_num);
    write_register(CFG_LAST_MAC, first_num + 32'd6);
    run_phase(90, 20, 20, 30, -1);
    settle();

    // back-to-back stretch: no gaps on either side
    gaps_on = 1'b0;
    stall_on = 1'b0;
    write_register(CFG_HUB_MODE, 32'd0);
    write_register(CFG_FIRST_MAC, 32'hFFFF_FFF8);
    run_phase(90, 25, 20, 25, -1);
    settle();
    gaps_on = 1'b1;
    stall_on = 1'b1;

    write_register(CFG_FIRST_MAC, 32'd0);
    write_register(CFG_LAST_MAC, 32'd0);
    run_phase(52, 25, 15, 30, -1);
    settle();

    $display("Scored %0d port results from %0d requests: connects, assignments, drops,",
             results_checked, requests_sent);
    $display("unicast/multicast/hub frames, full table, range exhaustion, long hold-off.");
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> files.f
src/vsft_pkg.sv
src/vsft_ctrl.sv
src/vsft_datapath.sv
src/virtual_switch_forwarding_table_core.sv
sim/virtual_switch_forwarding_table_core_test.sv
